// ===== design/wavetable_voice_mixer_macros.svh =====
// Assertion shorthands shared by the mixer RTL.
// Every property samples on clk and is disabled while rst is high.
`ifndef WAVETABLE_VOICE_MIXER_MACROS_SVH
`define WAVETABLE_VOICE_MIXER_MACROS_SVH

// Condition holds on every enabled clock edge
`define WVM_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define WVM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define WVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wvm_pkg.sv =====
package wvm_pkg;

  // Input item kinds carried on tuser
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_VOICE = 2'd1,
    OP_TABLE = 2'd2
  } opcode_t;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int VOICE_W  = 3;
  localparam int STEP_W   = 26;
  localparam int TIDX_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int TOP_W    = 16;
  localparam int FRAC_W   = 16;

  // Input tdata layout, lowest bit first
  localparam int VOICE_LSB  = 0;
  localparam int STEP_LSB   = VOICE_LSB + VOICE_W;
  localparam int ACTIVE_LSB = STEP_LSB + STEP_W;
  localparam int TIDX_LSB   = ACTIVE_LSB + 1;
  localparam int SAMPLE_LSB = TIDX_LSB + TIDX_W;
  localparam int IN_BITS    = SAMPLE_LSB + SAMPLE_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Reset value of the PWM top register
  localparam logic [TOP_W-1:0] TOP_RESET = 16'd4095;

  // Averaging divider: one quotient bit per step
  localparam int DIV_STEPS = LEVEL_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  // Mix times PWM period
  localparam int PROD_W = LEVEL_W + TOP_W + 1;

endpackage

// ===== design/wvm_ram.sv =====
module wvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/wavetable_voice_mixer.sv =====
// Wavetable voice mixer: several oscillator voices share one sample table and
// are averaged into a PWM compare level.
// Input channel s_axis: tuser carries the item kind (sample tick, voice event,
// table write), tdata the payload. Table writes complete on acceptance; a voice
// event reads the voice entry, then writes it back in ST_VEV keeping its phase.
// A sample tick walks the voice memory one voice per cycle, updates each
// active phase, reads the sample table, then runs a 16-step restoring divide
// for the average and one multiply by the PWM period. A tick occupies the
// block from acceptance until ST_OUT loads its level into the output register;
// the voice walk and the bit-serial divide set its length. The level then
// shows on m_axis.
// Output channel m_axis: one pwm_level per tick, from an output register; the
// block takes new items while a level waits there, and only a further tick
// result stalls until the receiver takes the waiting one.
// cfg_we/cfg_wdata write pwm_top at any edge; write it only while idle.
// Reset: voices read as silent with zero phase and step, pwm_top returns to
// 4095, output empties. The sample table is not cleared; load it first.
`include "wavetable_voice_mixer_macros.svh"

module wavetable_voice_mixer
  import wvm_pkg::*;
#(
  parameter int TABLE_SIZE  = 1024,
  parameter int VOICE_COUNT = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  // tuser: opcode[1:0]
  input  logic [OPCODE_W-1:0]   s_axis_tuser,
  // tdata: voice[2:0], voice_step[28:3], voice_active[29],
  //        table_index[39:30], table_sample[55:40]
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: pwm_level[15:0]
  output logic [LEVEL_W-1:0]    m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we,
  input  logic [TOP_W-1:0]      cfg_wdata
);

  localparam int T_ADDR_W  = $clog2(TABLE_SIZE);
  localparam int PHASE_W   = T_ADDR_W + FRAC_W;
  localparam int VI_W      = VOICE_COUNT > 1 ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W     = $clog2(VOICE_COUNT + 1);
  localparam int REM_W     = CNT_W + 1;
  localparam int SUM_W     = SAMPLE_W + 1 + $clog2(VOICE_COUNT);
  localparam int STEP_CW   = (PHASE_W > STEP_W ? PHASE_W : STEP_W) + 1;
  localparam int TIDX_CW   = (T_ADDR_W > TIDX_W ? T_ADDR_W : TIDX_W) + 1;
  localparam int VOICE_CW  = (VI_W > VOICE_W ? VI_W : VOICE_W) + 1;

  localparam logic [STEP_CW-1:0] SPAN_STEP  = STEP_CW'(TABLE_SIZE) << FRAC_W;
  localparam logic [PHASE_W:0]   SPAN_PHASE = (PHASE_W + 1)'(TABLE_SIZE) << FRAC_W;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] step;
    logic               en;
  } voice_entry_t;

  localparam int VE_W = $bits(voice_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEV,
    ST_TICK,
    ST_DSET,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  state_t                state;
  logic [TOP_W-1:0]      pwm_top;
  logic [VOICE_COUNT-1:0] voice_valid;
  logic [VI_W-1:0]       rd_idx;
  logic                  issue_more;
  logic                  s1_valid;
  logic [VI_W-1:0]       s1_idx;
  logic                  s2_valid;
  logic                  s2_en;
  logic [PHASE_W-1:0]    ev_step;
  logic                  ev_en;
  logic [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]      count;
  logic [REM_W-1:0]      rem;
  logic [LEVEL_W-1:0]    quo;
  logic [DIVCNT_W-1:0]   div_cnt;
  logic [PROD_W-1:0]     product;
  logic [LEVEL_W-1:0]    out_data;
  logic                  out_valid;

  logic                  in_accept;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [VOICE_W-1:0]    in_voice;
  logic [STEP_W-1:0]     in_step;
  logic                  in_active;
  logic [TIDX_W-1:0]     in_tidx;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [VOICE_CW-1:0]   voice_ext;
  logic                  voice_ok;
  logic [STEP_CW-1:0]    step_ext;
  logic [STEP_CW-1:0]    step_sat;
  logic [TIDX_CW-1:0]    tidx_ext;
  logic                  tidx_ok;

  logic                  vram_we;
  logic [VI_W-1:0]       vram_waddr;
  voice_entry_t          vram_wentry;
  logic                  vram_re;
  logic [VI_W-1:0]       vram_raddr;
  logic [VE_W-1:0]       vram_rdata;
  voice_entry_t          s1_entry;

  logic                  tram_we;
  logic                  tram_re;
  logic [T_ADDR_W-1:0]   tram_raddr;
  logic [SAMPLE_W-1:0]   tram_rdata;

  logic [PHASE_W:0]      p_sum;
  logic [PHASE_W:0]      p_wrap;
  logic [PHASE_W-1:0]    new_phase;

  logic [REM_W-1:0]      trial;
  logic [REM_W-1:0]      count_ext;
  logic                  div_ge;
  logic [LEVEL_W-1:0]    mix;
  logic [TOP_W:0]        period;
  logic [PROD_W-1:0]     product_next;

  // Unpack the input transaction and check its ranges
  always_comb begin
    in_accept = s_axis_tvalid && s_axis_tready;
    in_opcode = s_axis_tuser;
    in_voice  = s_axis_tdata[VOICE_LSB +: VOICE_W];
    in_step   = s_axis_tdata[STEP_LSB +: STEP_W];
    in_active = s_axis_tdata[ACTIVE_LSB];
    in_tidx   = s_axis_tdata[TIDX_LSB +: TIDX_W];
    in_sample = s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];
    voice_ext = VOICE_CW'(in_voice);
    voice_ok  = voice_ext < VOICE_CW'(VOICE_COUNT);
    step_ext  = STEP_CW'(in_step);
    step_sat  = (step_ext >= SPAN_STEP) ? (SPAN_STEP - 1'b1) : step_ext;
    tidx_ext  = TIDX_CW'(in_tidx);
    tidx_ok   = tidx_ext < TIDX_CW'(TABLE_SIZE);
  end

  // Voice entry as read; a never-written voice reads as all zero
  always_comb begin
    s1_entry = voice_valid[s1_idx] ? voice_entry_t'(vram_rdata) : '0;
  end

  // Advance the phase and wrap it once past the table end
  always_comb begin
    p_sum     = {1'b0, s1_entry.phase} + {1'b0, s1_entry.step};
    p_wrap    = (p_sum >= SPAN_PHASE) ? (p_sum - SPAN_PHASE) : p_sum;
    new_phase = p_wrap[PHASE_W-1:0];
  end

  // Voice memory ports
  always_comb begin
    vram_re    = 1'b0;
    vram_raddr = rd_idx;
    if (state == ST_IDLE && in_accept) begin
      if (in_opcode == OP_TICK) begin
        vram_re    = 1'b1;
        vram_raddr = '0;
      end else if (in_opcode == OP_VOICE && voice_ok) begin
        vram_re    = 1'b1;
        vram_raddr = voice_ext[VI_W-1:0];
      end
    end else if (state == ST_TICK && issue_more) begin
      vram_re = 1'b1;
    end

    vram_waddr  = s1_idx;
    vram_wentry = s1_entry;
    vram_we     = 1'b0;
    if (state == ST_VEV) begin
      vram_we          = 1'b1;
      vram_wentry.step = ev_step;
      vram_wentry.en   = ev_en;
    end else if (state == ST_TICK && s1_valid && s1_entry.en) begin
      vram_we           = 1'b1;
      vram_wentry.phase = new_phase;
    end
  end

  // Sample table ports
  always_comb begin
    tram_we    = (state == ST_IDLE) && in_accept && (in_opcode == OP_TABLE) && tidx_ok;
    tram_re    = (state == ST_TICK) && s1_valid && s1_entry.en;
    tram_raddr = new_phase[PHASE_W-1:FRAC_W];
  end

  // Restoring divide step and period multiply
  always_comb begin
    trial        = {rem[REM_W-2:0], quo[LEVEL_W-1]};
    count_ext    = REM_W'(count);
    div_ge       = trial >= count_ext;
    mix          = (count == '0) ? '0 : quo;
    period       = {1'b0, pwm_top} + 1'b1;
    product_next = PROD_W'(mix) * PROD_W'(period);
  end

  wvm_ram #(
    .WIDTH (VE_W),
    .DEPTH (VOICE_COUNT)
  ) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wentry),
    .re    (vram_re),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  wvm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_SIZE)
  ) u_table_ram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tidx_ext[T_ADDR_W-1:0]),
    .wdata (in_sample),
    .re    (tram_re),
    .raddr (tram_raddr),
    .rdata (tram_rdata)
  );

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pwm_top     <= TOP_RESET;
      voice_valid <= '0;
      issue_more  <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        pwm_top <= cfg_wdata;
      end
      if (vram_we) begin
        voice_valid[vram_waddr] <= 1'b1;
      end
      // in ST_OUT the reload below decides the output register
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_opcode)
              OP_TICK: begin
                s1_valid   <= 1'b1;
                s1_idx     <= '0;
                rd_idx     <= VI_W'(1);
                issue_more <= (VOICE_COUNT > 1);
                sum        <= '0;
                count      <= '0;
                state      <= ST_TICK;
              end
              OP_VOICE: begin
                if (voice_ok) begin
                  s1_idx  <= voice_ext[VI_W-1:0];
                  ev_step <= step_sat[PHASE_W-1:0];
                  ev_en   <= in_active;
                  state   <= ST_VEV;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_VEV: begin
          state <= ST_IDLE;
        end

        ST_TICK: begin
          // issue the next voice read
          if (issue_more) begin
            s1_valid   <= 1'b1;
            s1_idx     <= rd_idx;
            rd_idx     <= rd_idx + 1'b1;
            issue_more <= rd_idx != VI_W'(VOICE_COUNT - 1);
          end else begin
            s1_valid <= 1'b0;
          end
          s2_valid <= s1_valid;
          s2_en    <= s1_entry.en;
          // accumulate the sample of an active voice
          if (s2_valid && s2_en) begin
            sum   <= sum + SUM_W'(tram_rdata);
            count <= count + 1'b1;
          end
          if (!issue_more && !s1_valid) begin
            state <= ST_DSET;
          end
        end

        ST_DSET: begin
          // high part of the sum is already below the count
          rem     <= REM_W'(sum[SUM_W-1:FRAC_W]);
          quo     <= sum[LEVEL_W-1:0];
          div_cnt <= '0;
          state   <= ST_DIV;
        end

        ST_DIV: begin
          rem     <= div_ge ? (trial - count_ext) : trial;
          quo     <= {quo[LEVEL_W-2:0], div_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIVCNT_W'(DIV_STEPS - 1)) begin
            state <= ST_MUL;
          end
        end

        ST_MUL: begin
          product <= product_next;
          state   <= ST_OUT;
        end

        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid || m_axis_tready) begin
            out_data  <= product[LEVEL_W+FRAC_W-1:FRAC_W];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Write-back never targets the entry being fetched in the same cycle
  `WVM_ASSERT_IMPLIES(a_vram_no_overlap, vram_we && vram_re, vram_waddr != vram_raddr, "voice memory read and write hit the same entry")
  // Table loads only happen between ticks
  `WVM_ASSERT_IMPLIES(a_tram_write_idle, tram_we, state == ST_IDLE && !tram_re, "table write during a tick")
  // Active count stays within the voice count
  `WVM_ASSERT_IMPLIES(a_count_bound, state == ST_DSET || state == ST_DIV, count <= CNT_W'(VOICE_COUNT), "active count exceeds voice count")
  // Table data arrives only while the voice walk runs
  `WVM_ASSERT_IMPLIES(a_s2_in_tick, s2_valid, state == ST_TICK, "table read data outside the voice walk")
  // Divide ends after its last step
  `WVM_ASSERT_NEXT(a_div_end, state == ST_DIV && div_cnt == DIVCNT_W'(DIV_STEPS - 1), state == ST_MUL, "divide did not finish")

endmodule

// ===== verif/tb.sv =====
module tb;
  import wvm_pkg::*;

  localparam int VOICES       = 7;
  localparam int TABLE_DEPTH  = 1024;
  localparam logic [STEP_W:0] PHASE_SPAN = (STEP_W + 1)'(TABLE_DEPTH) << FRAC_W;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [VOICE_W-1:0]  VOICE_MISSING = 3'd7;
  localparam logic [STEP_W-1:0]   STEP_MAX = {STEP_W{1'b1}};
  localparam logic [STEP_W-1:0]   STEP_ONE = 26'h001_0000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 212;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [VOICE_W-1:0]  voice;
    logic [STEP_W-1:0]   step;
    logic                active;
    logic [TIDX_W-1:0]   tidx;
    logic [SAMPLE_W-1:0] tsample;
  } mixer_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [OPCODE_W-1:0]   s_axis_tuser = '0;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [LEVEL_W-1:0]    m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [TOP_W-1:0]      cfg_wdata = '0;

  // Shadow state of the oscillators, the sample table and the PWM top
  logic [STEP_W-1:0]   osc_phase [VOICES];
  logic [STEP_W-1:0]   osc_step [VOICES];
  logic                osc_on [VOICES];
  logic [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
  bit                  wave_loaded [TABLE_DEPTH];
  logic [TOP_W-1:0]    pwm_top_q = TOP_RESET;

  logic [LEVEL_W-1:0] pending_levels[$];
  int fail_count = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_len = 0;
  int quiet_cycles = 0;

  wavetable_voice_mixer u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Advance one voice by its step, wrapping once at the table length
  function automatic logic [STEP_W-1:0] next_phase(int v);
    logic [STEP_W:0] sum;
    sum = osc_phase[v] + osc_step[v];
    if (sum >= PHASE_SPAN) sum = sum - PHASE_SPAN;
    return sum[STEP_W-1:0];
  endfunction

  // Average the active voices and scale by the PWM period
  function automatic logic [LEVEL_W-1:0] mix_level_after_tick();
    logic [SAMPLE_W+2:0]     total;
    int unsigned             active_n;
    logic [SAMPLE_W-1:0]     avg;
    logic [TOP_W:0]          period;
    logic [LEVEL_W+TOP_W:0]  scaled;
    int                      v;
    total = '0;
    active_n = 0;
    for (v = 0; v < VOICES; v++) begin
      if (osc_on[v]) begin
        osc_phase[v] = next_phase(v);
        total += wave_mem[osc_phase[v][STEP_W-1:FRAC_W]];
        active_n++;
      end
    end
    avg = (active_n == 0) ? '0 : SAMPLE_W'(total / active_n);
    period = {1'b0, pwm_top_q} + 1'b1;
    scaled = avg * period;
    return scaled[LEVEL_W+FRAC_W-1:FRAC_W];
  endfunction

  // Update the shadow state for one accepted transaction
  function automatic void apply_item(mixer_item_t it);
    case (it.op)
      OP_TICK: begin
        pending_levels.push_back(mix_level_after_tick());
      end
      OP_VOICE: begin
        if (it.voice < VOICES) begin
          osc_step[it.voice] = (it.step >= PHASE_SPAN) ? STEP_W'(PHASE_SPAN - 1) : it.step;
          osc_on[it.voice] = it.active;
        end
      end
      OP_TABLE: begin
        wave_mem[it.tidx] = it.tsample;
        wave_loaded[it.tidx] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Fill every field with noise; callers override what matters
  function automatic mixer_item_t random_item(logic [OPCODE_W-1:0] op);
    mixer_item_t it;
    it.op = op;
    it.voice = VOICE_W'($urandom);
    it.step = STEP_W'($urandom);
    it.active = 1'($urandom);
    it.tidx = TIDX_W'($urandom);
    it.tsample = SAMPLE_W'($urandom);
    return it;
  endfunction

  // Offer one transaction, idling at random first, and wait for acceptance
  task automatic send_item(mixer_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tuser <= it.op;
    s_axis_tdata <= {it.tsample, it.tidx, it.active, it.step, it.voice};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_item(it);
    items_sent++;
  endtask

  task automatic send_table(logic [TIDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
    mixer_item_t it;
    it = random_item(OP_TABLE);
    it.tidx = idx;
    it.tsample = value;
    send_item(it);
  endtask

  task automatic send_voice(logic [VOICE_W-1:0] v, logic [STEP_W-1:0] step, logic on);
    mixer_item_t it;
    it = random_item(OP_VOICE);
    it.voice = v;
    it.step = step;
    it.active = on;
    send_item(it);
  endtask

  // Load any entry this tick will read that was never written, then tick
  task automatic send_tick();
    logic [STEP_W-1:0] np;
    int                v;
    for (v = 0; v < VOICES; v++) begin
      if (osc_on[v]) begin
        np = next_phase(v);
        if (!wave_loaded[np[STEP_W-1:FRAC_W]])
          send_table(np[STEP_W-1:FRAC_W], SAMPLE_W'($urandom));
      end
    end
    send_item(random_item(OP_TICK));
  endtask

  // Drop valid, wait for every level, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pwm_top(logic [TOP_W-1:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    pwm_top_q = value;
  endtask

  task automatic test_directed_mixing();
    int          v;
    send_table(10'd0, 16'hFFFF);
    send_table(10'd1023, 16'h0000);
    send_table(10'd1, 16'h8000);
    send_table(10'd2, 16'h1234);
    // no voice active: level is zero
    send_tick();
    // unused opcode and missing voice are dropped
    send_item(random_item(OP_UNUSED));
    send_voice(VOICE_MISSING, STEP_ONE, 1'b1);
    send_tick();
    send_voice(3'd0, STEP_ONE, 1'b1);
    send_tick();
    // largest step wraps the phase on each tick after the first
    send_voice(3'd6, STEP_MAX, 1'b1);
    send_tick();
    send_tick();
    // disable then re-enable: phase must be kept
    send_voice(3'd0, STEP_ONE, 1'b0);
    send_tick();
    send_voice(3'd0, '0, 1'b1);
    send_tick();
    // all voices mixed
    for (v = 1; v < VOICES - 1; v++)
      send_voice(VOICE_W'(v), STEP_W'($urandom_range(0, 32'h3FFFF)), 1'b1);
    send_tick();
    wait_idle();
  endtask

  task automatic test_pwm_top_extremes();
    set_pwm_top('0);
    send_tick();
    send_tick();
    set_pwm_top('1);
    send_tick();
    send_tick();
    set_pwm_top(TOP_RESET);
  endtask

  // Hold the receiver off while ticks keep coming so the input stalls
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_len = HOLD_CYCLES;
    repeat (10) send_tick();
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int          tx_pct [4] = '{0, 78, 0, 27};
    int          rx_pct [4] = '{0, 0, 78, 27};
    int          ph;
    int          target;
    int          pick;
    logic [STEP_W-1:0] step;
    for (ph = 0; ph < 4; ph++) begin
      set_pwm_top(TOP_W'($urandom));
      tx_idle_pct = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_tick();
        end else if (pick < 65) begin
          case ($urandom_range(3))
            0: step = STEP_W'($urandom_range(0, 32'h3FFFF));
            1: step = STEP_W'($urandom);
            2: step = $urandom_range(1) ? STEP_MAX : '0;
            default: step = STEP_W'($urandom_range(0, 32'hFFFF));
          endcase
          send_voice(VOICE_W'($urandom_range(0, 7)), step, $urandom_range(3) != 0);
        end else if (pick < 92) begin
          send_table(TIDX_W'($urandom), SAMPLE_W'($urandom));
        end else begin
          send_item(random_item(OP_UNUSED));
        end
      end
    end
    wait_idle();
  endtask

  // Receiver: random stalls, or one long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Check each level transaction against the oldest tick
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_levels.size() == 0) begin
        $error("pwm_level with no tick pending: expected none, actual %0d", m_axis_tdata);
        fail_count++;
      end else if (m_axis_tdata !== pending_levels[0]) begin
        $error("pwm_level mismatch: expected %0d, actual %0d",
               pending_levels[0], m_axis_tdata);
        fail_count++;
        void'(pending_levels.pop_front());
      end else begin
        void'(pending_levels.pop_front());
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int v;
    for (v = 0; v < VOICES; v++) begin
      osc_phase[v] = '0;
      osc_step[v] = '0;
      osc_on[v] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_mixing();
    test_pwm_top_extremes();
    test_output_backpressure();
    test_random_traffic();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== wavetable_voice_mixer.f =====
+incdir+design
design/wvm_pkg.sv
design/wvm_ram.sv
design/wavetable_voice_mixer.sv
verif/tb.sv
